FILE: rtl/core/hcbp_pkg.sv
// ============================================================================
// hcbp_pkg: shared types and constants for the huffman code bit packer
// Item op codes, sequencer states and the fixed field widths of the block.
// ============================================================================
package hcbp_pkg;

    // fixed field widths
    localparam int OP_W   = 2;
    localparam int SYM_W  = 8;
    localparam int WORD_W = 32;
    localparam int BYTE_W = 8;

    // defaults for the top level parameters
    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_CODE_WIDTH  = 32;

    // item op codes
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SHIFT,
        ST_FLUSH
    } state_t;

endpackage

FILE: rtl/core/huffman_code_bit_packer.sv
// ============================================================================
// huffman_code_bit_packer
// Code table lookup and MSB-first bit packing into bytes.
// ============================================================================
// Usage:
//   item channel (item_valid / item_stall) carries op, symbol and code_word.
//   op load writes one code table word, op encode looks up the code of a
//   symbol and packs its bits, op flush pads the partial byte with zeros.
//   result channel (result_valid / result_stall) carries packed_byte and
//   last_of_run, which marks the final byte caused by one item.
// Sequencing:
//   load writes the table when accepted. encode is accepted, reads the
//   table, then packs one byte per cycle while the result register is free,
//   and merges leftover bits into the accumulator. flush pads and emits the
//   partial byte, if any. The table has a single read port.
//   One item is in work at a time; item_stall is high while it is.
// Reset:
//   clears the bit accumulator, the pending count and the result valid flag.
//   The code table is not cleared; entries must be loaded before use.
// Stall:
//   a finished byte waits in the result register; packing holds while the
//   result register is full and result_stall is high.
// ============================================================================
module huffman_code_bit_packer #(
    parameter int TABLE_DEPTH = hcbp_pkg::DEF_TABLE_DEPTH,
    parameter int CODE_WIDTH  = hcbp_pkg::DEF_CODE_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // item channel
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic [hcbp_pkg::OP_W-1:0]    op,
    input  logic [hcbp_pkg::SYM_W-1:0]   symbol,
    input  logic [hcbp_pkg::WORD_W-1:0]  code_word,
    // result channel
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [hcbp_pkg::BYTE_W-1:0]  packed_byte,
    output logic                         last_of_run
);

    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int STORE_W = (CODE_WIDTH < hcbp_pkg::WORD_W) ? CODE_WIDTH
                                                               : hcbp_pkg::WORD_W;
    localparam int W       = hcbp_pkg::WORD_W;
    localparam int B       = hcbp_pkg::BYTE_W;

    // code table memory
    logic [STORE_W-1:0] code_mem [TABLE_DEPTH];
    logic [STORE_W-1:0] rd_data_reg;
    logic               in_range_reg;

    hcbp_pkg::state_t   state_reg, state_next;
    logic [B-1:0]       acc_reg, acc_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic [5:0]         rem_reg, rem_next;
    logic [W-1:0]       code_reg, code_next;
    logic               out_valid_reg, out_valid_next;
    logic [B-1:0]       out_byte_reg, out_byte_next;
    logic               out_last_reg, out_last_next;

    logic               accept;
    logic               in_range;
    logic               mem_wr;
    logic               out_free;
    logic               emit;
    logic [W-1:0]       word;
    logic [5:0]         blen;
    logic [3:0]         need;
    logic [W+B-1:0]     window;
    logic [W-1:0]       code_sh;
    logic [5:0]         left;

    assign accept     = item_valid && !item_stall;
    assign item_stall = (state_reg != hcbp_pkg::ST_IDLE);
    assign in_range   = (int'(symbol) < TABLE_DEPTH);
    assign mem_wr     = accept && (op == hcbp_pkg::OP_LOAD) && in_range;
    assign out_free   = !out_valid_reg || !result_stall;

    assign result_valid = out_valid_reg;
    assign packed_byte  = out_byte_reg;
    assign last_of_run  = out_last_reg;

    // table write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            code_mem[symbol[IDX_W-1:0]] <= code_word[STORE_W-1:0];
        end
        rd_data_reg  <= code_mem[symbol[IDX_W-1:0]];
        in_range_reg <= in_range;
    end

    // looked-up word and its bit length
    always_comb
    begin
        word = in_range_reg ? W'(rd_data_reg) : '0;
        blen = '0;
        for (int i = 0; i < W; i++)
        begin
            if (word[i])
            begin
                blen = 6'(i + 1);
            end
        end
    end

    // packing datapath terms
    assign need    = 4'(B) - 4'(cnt_reg);
    assign window  = {acc_reg, code_reg};
    assign code_sh = code_reg << need;
    assign left    = rem_reg - 6'(need);

    // next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        code_next      = code_reg;
        emit           = 1'b0;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            hcbp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == hcbp_pkg::OP_ENCODE)
                    begin
                        state_next = hcbp_pkg::ST_READ;
                    end
                    else if (op == hcbp_pkg::OP_FLUSH)
                    begin
                        state_next = hcbp_pkg::ST_FLUSH;
                    end
                end
            end

            // drop the sentinel and left-align the code bits
            hcbp_pkg::ST_READ:
            begin
                code_next = W'({word, 1'b0} << (6'd32 - blen));
                rem_next  = (blen == '0) ? '0 : blen - 6'd1;
                if ((blen == '0) || (blen == 6'd1))
                begin
                    state_next = hcbp_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = hcbp_pkg::ST_SHIFT;
                end
            end

            // one byte per cycle while the result register is free; leftover bits go to the accumulator
            hcbp_pkg::ST_SHIFT:
            begin
                if (6'(need) <= rem_reg)
                begin
                    if (out_free)
                    begin
                        emit          = 1'b1;
                        out_byte_next = B'(window >> (6'd24 + 6'(cnt_reg)));
                        out_last_next = (left < 6'(B));
                        if (left < 6'(B))
                        begin
                            acc_next   = B'(code_sh >> (6'd32 - left));
                            cnt_next   = left[2:0];
                            rem_next   = '0;
                            state_next = hcbp_pkg::ST_IDLE;
                        end
                        else
                        begin
                            acc_next  = '0;
                            cnt_next  = '0;
                            rem_next  = left;
                            code_next = code_sh;
                        end
                    end
                end
                else
                begin
                    acc_next   = B'(window >> (6'd32 - rem_reg));
                    cnt_next   = cnt_reg + rem_reg[2:0];
                    rem_next   = '0;
                    state_next = hcbp_pkg::ST_IDLE;
                end
            end

            // pad the partial byte with zeros on the right
            hcbp_pkg::ST_FLUSH:
            begin
                if (cnt_reg == '0)
                begin
                    acc_next   = '0;
                    state_next = hcbp_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    emit          = 1'b1;
                    out_byte_next = B'(acc_reg << (4'(B) - 4'(cnt_reg)));
                    out_last_next = 1'b1;
                    acc_next      = '0;
                    cnt_next      = '0;
                    state_next    = hcbp_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = hcbp_pkg::ST_IDLE;
            end
        endcase

        // result register holds until taken
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && result_stall;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hcbp_pkg::ST_IDLE;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        code_reg     <= code_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top: self-checking bench for the huffman code bit packer
// Loads code table words, encodes symbols and flushes partial bytes, while
// the item channel idles and the result channel stalls at random. A cycle-free predictor of the packer
// computes the expected bytes for each accepted item, and each output byte
// is compared in order against them.
// ============================================================================
module tb_top;

    import hcbp_pkg::*;

    // op code the block ignores
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int ITEMS_PER_PHASE = 90;
    localparam int QUIET_LIMIT     = 2000;
    localparam int HOLD_CYCLES     = 300;
    localparam int HOLD_AFTER      = 40;
    localparam int DRAIN_CYCLES    = 20;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [SYM_W-1:0]  sym;
        logic [WORD_W-1:0] cw;
    } code_item_t;

    typedef struct {
        logic [BYTE_W-1:0] value;
        logic              last;
    } byte_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic              item_valid   = 1'b0;
    logic              item_stall;
    logic [OP_W-1:0]   op           = '0;
    logic [SYM_W-1:0]  symbol       = '0;
    logic [WORD_W-1:0] code_word    = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic [BYTE_W-1:0] packed_byte;
    logic              last_of_run;

    // stimulus side
    code_item_t   pending_items[$];
    int           loaded_syms[$];
    bit           sym_loaded[0:255];
    int           n_queued   = 0;
    int           n_counted  = 0;
    int           n_accepted = 0;
    int           phase      = 0;

    // predictor state
    logic [WORD_W-1:0] code_mem[0:255];
    logic [BYTE_W-1:0] acc_bits  = '0;
    int                acc_count = 0;
    byte_result_t      expected_bytes[$];

    // checking side
    int  n_results    = 0;
    int  n_fail       = 0;
    int  hold_left    = 0;
    bit  hold_done    = 1'b0;
    int  quiet_cycles = 0;

    code_item_t   drive_item;
    byte_result_t want;

    huffman_code_bit_packer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .op           (op),
        .symbol       (symbol),
        .code_word    (code_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .packed_byte  (packed_byte),
        .last_of_run  (last_of_run)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor: update state and queue the bytes one item causes
    task automatic pack_item(input logic [OP_W-1:0] item_op, input logic [SYM_W-1:0] sym,
                             input logic [WORD_W-1:0] cw);
        logic [WORD_W-1:0] word;
        int                nbits;
        int                n_new;
        int                i;
        n_new = 0;
        case (item_op)
            OP_LOAD:
                code_mem[sym] = cw;
            OP_ENCODE:
            begin
                word  = code_mem[sym];
                // code length is the position of the sentinel one
                nbits = 0;
                for (i = 0; i < WORD_W; i++)
                    if (word[i])
                        nbits = i;
                for (i = nbits - 1; i >= 0; i--)
                begin
                    acc_bits = {acc_bits[BYTE_W-2:0], word[i]};
                    acc_count++;
                    if (acc_count == BYTE_W)
                    begin
                        expected_bytes.push_back('{acc_bits, 1'b0});
                        n_new++;
                        acc_bits  = '0;
                        acc_count = 0;
                    end
                end
                if (n_new > 0)
                    expected_bytes[expected_bytes.size() - 1].last = 1'b1;
            end
            OP_FLUSH:
            begin
                // pad leftover bits with zeros on the right
                if (acc_count > 0)
                    expected_bytes.push_back('{acc_bits << (BYTE_W - acc_count), 1'b1});
                acc_bits  = '0;
                acc_count = 0;
            end
            default:
                ;
        endcase
    endtask

    task automatic add_item(input logic [OP_W-1:0] item_op, input int sym,
                            input logic [WORD_W-1:0] cw);
        pending_items.push_back('{item_op, sym[SYM_W-1:0], cw});
        n_queued++;
        if (item_op != OP_UNUSED)
            n_counted++;
        if (item_op == OP_LOAD && !sym_loaded[sym])
        begin
            sym_loaded[sym] = 1'b1;
            loaded_syms.push_back(sym);
        end
    endtask

    // random code word, mostly short codes with a sentinel one
    function automatic logic [WORD_W-1:0] random_code_word();
        int sel;
        int len;
        sel = $urandom_range(0, 99);
        if (sel < 5)
            return $urandom_range(0, 1);
        if (sel < 15)
            return $urandom;
        if (sel < 70)
            len = $urandom_range(1, 10);
        else
            len = $urandom_range(11, 31);
        return (32'd1 << len) | ($urandom & ((32'd1 << len) - 32'd1));
    endfunction

    // loads followed by encodes of loaded symbols, with flushes and noise
    task automatic add_random_items(input int target);
        int r;
        int k;
        int n;
        while (n_counted < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                add_item(OP_UNUSED, $urandom_range(0, 255), $urandom);
            else if (r < 14)
                add_item(OP_FLUSH, $urandom_range(0, 255), $urandom);
            else
            begin
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++)
                    add_item(OP_LOAD, $urandom_range(0, 255), random_code_word());
                n = $urandom_range(2, 10);
                for (k = 0; k < n; k++)
                    add_item(OP_ENCODE,
                             loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                             $urandom);
                if ($urandom_range(0, 1))
                    add_item(OP_FLUSH, $urandom_range(0, 255), $urandom);
            end
        end
    endtask

    // driver: offer the next pending item once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            op         <= '0;
            symbol     <= '0;
            code_word  <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                pack_item(op, symbol, code_word);
                n_accepted++;
            end
            if (!item_valid || !item_stall)
            begin
                if (pending_items.size() > 0 &&
                    $urandom_range(0, 99) >= (phase == 0 ? 28 : phase == 1 ? 50 : 0))
                begin
                    drive_item = pending_items.pop_front();
                    item_valid <= 1'b1;
                    op         <= drive_item.op;
                    symbol     <= drive_item.sym;
                    code_word  <= drive_item.cw;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // monitor: check each byte, then pick the stall for the next cycle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                n_results++;
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected byte: packed_byte %0h last_of_run %0b",
                           packed_byte, last_of_run);
                    n_fail++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (packed_byte !== want.value)
                    begin
                        $error("packed_byte: expected %0h, actual %0h", want.value, packed_byte);
                        n_fail++;
                    end
                    if (last_of_run !== want.last)
                    begin
                        $error("last_of_run: expected %0b, actual %0b", want.last, last_of_run);
                        n_fail++;
                    end
                end
            end
            // one long hold-off so the block backs up onto its input
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (!hold_done && n_results >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(0, 99) < (phase == 0 ? 50 : phase == 1 ? 28 : 0));
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus and end of run
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty codes, longest codes, flush corners, ignored op
        add_item(OP_LOAD, 0, 32'h0000_0000);
        add_item(OP_LOAD, 255, 32'h0000_0001);
        add_item(OP_LOAD, 1, 32'hFFFF_FFFF);
        add_item(OP_LOAD, 2, 32'h8000_0000);
        add_item(OP_LOAD, 3, 32'h0000_0002);
        add_item(OP_LOAD, 4, 32'h0000_01A5);
        add_item(OP_UNUSED, 255, 32'hFFFF_FFFF);
        add_item(OP_FLUSH, 0, 32'h0);
        add_item(OP_ENCODE, 0, 32'h0);
        add_item(OP_ENCODE, 255, 32'hFFFF_FFFF);
        add_item(OP_ENCODE, 4, 32'h0);
        add_item(OP_ENCODE, 1, 32'h0);
        add_item(OP_ENCODE, 1, 32'h0);
        add_item(OP_ENCODE, 3, 32'h0);
        add_item(OP_FLUSH, 255, 32'hFFFF_FFFF);
        add_item(OP_FLUSH, 0, 32'h0);
        add_item(OP_ENCODE, 2, 32'h0);
        add_item(OP_ENCODE, 3, 32'h0);
        add_item(OP_ENCODE, 1, 32'h0);
        add_item(OP_FLUSH, 0, 32'h0);
        add_item(OP_LOAD, 4, 32'h5A5A_5A5A);
        add_item(OP_ENCODE, 4, 32'h0);
        add_item(OP_ENCODE, 4, 32'h0);
        add_item(OP_FLUSH, 0, 32'h0);

        // three phases with their own idle and stall rates, each drained before the next
        while (phase < 3)
        begin
            add_random_items(n_counted + ITEMS_PER_PHASE);
            do
                @(posedge clk);
            while (n_accepted != n_queued || expected_bytes.size() != 0);
            phase <= phase + 1;
            @(posedge clk);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_bytes.size() != 0)
        begin
            $error("%0d expected bytes never arrived", expected_bytes.size());
            n_fail++;
        end
        if (n_fail == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: huffman_code_bit_packer.f
rtl/core/hcbp_pkg.sv
rtl/core/huffman_code_bit_packer.sv
sim/tb_top.sv
